>>> sv/imuca_pkg.sv
// shared types, constants and the atan table of the attitude core
package imuca_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanEntries    = 24;

  localparam logic [24:0] Q16Deg360 = 25'd23592960;
  localparam logic [24:0] Q16Deg180 = 25'd11796480;
  localparam logic [16:0] BlendOld  = 17'd64225;
  localparam logic [11:0] BlendAcc  = 12'd1311;
  localparam logic [9:0]  MsPerSec  = 10'd1000;
  localparam logic [15:0] SensReset = 16'd33536;

  typedef enum logic [1:0] {
    CFG_OFF_X = 2'd0,
    CFG_OFF_Y = 2'd1,
    CFG_OFF_Z = 2'd2,
    CFG_SENS  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_INIT,
    ST_RDIV,
    ST_RFIN,
    ST_MUL,
    ST_DDIV,
    ST_DFIN,
    ST_BLEND,
    ST_HMOD,
    ST_HFIN
  } state_e;

  // atan(2^-i) in q16 degrees
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117305;
      5'd6:    v = 22'd58665;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/imu_complementary_attitude_core.sv
// complementary-filter attitude core: gyro rates, accel tilt, fused angles and heading
//
// one imu sample in, one result item out. the gyro rate dividers run one quotient bit per cycle
// (with the two square roots alongside), the rate times elapsed time product takes one ms bit
// per cycle, the divide by 1000 one bit per cycle (cordic runs beside the product and divide),
// and the heading wrap modulo 360 degrees one bit per cycle, plus the setup and finish states.
// a new sample is taken while the last result still waits at the output. angles and rates are
// signed q15.16 (degrees, degrees per second), the heading angle_z signed q8.16 degrees.
module imu_complementary_attitude_core #(
  parameter int unsigned CORDIC_STEPS = imuca_pkg::CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] accel_x_i,
  input  logic [15:0] accel_y_i,
  input  logic [15:0] accel_z_i,
  input  logic [15:0] gyro_raw_x_i,
  input  logic [15:0] gyro_raw_y_i,
  input  logic [15:0] gyro_raw_z_i,
  input  logic [15:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] angle_x_o,
  output logic [31:0] angle_y_o,
  output logic [24:0] angle_z_o,
  output logic [31:0] rate_x_o,
  output logic [31:0] rate_y_o,
  output logic [31:0] rate_z_o
);
  import imuca_pkg::*;

  localparam int unsigned StepsEff = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
  localparam int unsigned CW = 28;
  localparam logic [5:0] RdivLast = 6'd39;
  localparam logic [5:0] MulLast  = 6'd15;
  localparam logic [5:0] DdivLast = 6'd47;
  localparam logic [5:0] HmodLast = 6'd40;
  localparam logic [4:0] CordLast = 5'(StepsEff - 1);

  // control
  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       out_valid_q;
  logic       cord_run_q;
  logic [4:0] cord_cnt_q;
  logic       fin_go;

  // configuration
  logic [15:0] off_q [3];
  logic [15:0] sens_q;
  logic [15:0] sens_eff;

  // filter state
  logic [31:0] tilt_x_q, tilt_y_q;
  logic [24:0] heading_q;

  // latched sample
  logic [15:0] acc_q [3];
  logic [15:0] gyr_q [3];
  logic [15:0] ms_q;

  // squares and square roots, lane 0 feeds the x tilt, lane 1 the y tilt
  logic [30:0] sq_q [3];
  logic [47:0] sn_q [2];
  logic [47:0] sres_q [2];
  logic [47:0] sbit_q [2];

  // rate dividers
  logic [39:0] rnum_q [3];
  logic [15:0] rrem_q [3];
  logic        rneg_q [3];
  logic [31:0] rate_q [3];
  logic [31:0] rmag_q [3];

  // product and divide by 1000, one shift register per lane
  logic [47:0] md_q [3];
  logic [9:0]  drem_q [3];
  logic [15:0] msr_q;

  // cordic
  logic signed [CW-1:0] cx_q [2];
  logic signed [CW-1:0] cy_q [2];
  logic signed [24:0]   cz_q [2];
  logic                 czero_q [2];

  // blend and heading
  logic [31:0]        px_q, py_q;
  logic signed [49:0] blx_q, bly_q;
  logic [40:0]        hm_q;
  logic               hneg_q;
  logic [24:0]        hrem_q;

  // output registers
  logic [31:0] o_ax_q, o_ay_q;
  logic [24:0] o_az_q;
  logic [31:0] o_r_q [3];

  assign sens_eff = (sens_q == 16'd0) ? 16'd1 : sens_q;

  // combinational step values
  logic signed [16:0] gdiff [3];
  logic [15:0]        gmag [3];
  logic [16:0]        rt [3];
  logic               rge [3];
  logic [10:0]        dt [3];
  logic               dge [3];
  logic [47:0]        ssum [2];
  logic               sge [2];
  logic signed [CW-1:0] cxs [2];
  logic signed [CW-1:0] cys [2];
  logic signed [24:0]   catan;
  logic [25:0]        ht;
  logic               hge;
  logic [39:0]        rq_neg [3];
  logic [31:0]        rate_n [3];
  logic [31:0]        rmag_n [3];
  logic signed [39:0] dval [3];
  logic signed [40:0] pxw, pyw, hw;
  logic [31:0]        pxs, pys;
  logic [24:0]        hr;
  logic signed [25:0] hsg;
  logic signed [33:0] bx_sh, by_sh;
  logic [31:0]        nx, ny;

  function automatic logic [31:0] sat41(input logic signed [40:0] v);
    logic [31:0] r;
    if (v > 41'sh0007FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -41'sh00080000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh07FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -34'sh080000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gdiff[k] = $signed({gyr_q[k][15], gyr_q[k]}) - $signed({off_q[k][15], off_q[k]});
      gmag[k]  = gdiff[k][16] ? 16'(17'd0 - 17'(gdiff[k])) : gdiff[k][15:0];
      rt[k]    = {rrem_q[k], rnum_q[k][39]};
      rge[k]   = rt[k] >= {1'b0, sens_eff};
      dt[k]    = {drem_q[k], md_q[k][47]};
      dge[k]   = dt[k] >= {1'b0, MsPerSec};
      // rate saturation, sign and magnitude
      rq_neg[k] = 40'd0 - rnum_q[k];
      if (!rneg_q[k]) begin
        rate_n[k] = (rnum_q[k] > 40'h007FFFFFFF) ? 32'h7FFFFFFF : rnum_q[k][31:0];
        rmag_n[k] = rate_n[k];
      end else begin
        rate_n[k] = (rnum_q[k] > 40'h0080000000) ? 32'h80000000 : rq_neg[k][31:0];
        rmag_n[k] = (rnum_q[k] > 40'h0080000000) ? 32'h80000000 : rnum_q[k][31:0];
      end
      dval[k] = rneg_q[k] ? $signed(40'd0 - {1'b0, md_q[k][38:0]})
                          : $signed({1'b0, md_q[k][38:0]});
    end
    for (int k = 0; k < 2; k++) begin
      ssum[k] = sres_q[k] + sbit_q[k];
      sge[k]  = sn_q[k] >= ssum[k];
      cxs[k]  = cx_q[k] >>> cord_cnt_q;
      cys[k]  = cy_q[k] >>> cord_cnt_q;
    end
    catan = $signed({3'b000, atan_q16(cord_cnt_q)});
    ht  = {hrem_q, hm_q[40]};
    hge = ht >= {1'b0, Q16Deg360};
    // integration, sign follows whether accel z is positive
    if ($signed(acc_q[2]) > 16'sd0) begin
      pxw = $signed({{9{tilt_x_q[31]}}, tilt_x_q}) - 41'(dval[1]);
      pyw = $signed({{9{tilt_y_q[31]}}, tilt_y_q}) + 41'(dval[0]);
    end else begin
      pxw = $signed({{9{tilt_x_q[31]}}, tilt_x_q}) + 41'(dval[1]);
      pyw = $signed({{9{tilt_y_q[31]}}, tilt_y_q}) - 41'(dval[0]);
    end
    pxs = sat41(pxw);
    pys = sat41(pyw);
    hw  = $signed({{16{heading_q[24]}}, heading_q}) + 41'(dval[2]);
    // floor modulo fixup and wrap into (-180,180]
    hr = (hneg_q && hrem_q != 25'd0) ? Q16Deg360 - hrem_q : hrem_q;
    hsg = $signed({1'b0, hr});
    if (hr > Q16Deg180) hsg = $signed({1'b0, hr}) - $signed({1'b0, Q16Deg360});
    bx_sh = 34'(blx_q >>> 16);
    by_sh = 34'(bly_q >>> 16);
    nx = sat34(bx_sh);
    ny = sat34(by_sh);
  end

  assign fin_go = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 6'd1;
    case (state_q)
      ST_IDLE: begin
        cnt_d = 6'd0;
        if (in_valid_i) state_d = ST_SQ;
      end
      ST_SQ:   begin cnt_d = 6'd0; state_d = ST_INIT; end
      ST_INIT: begin cnt_d = 6'd0; state_d = ST_RDIV; end
      ST_RDIV: begin
        if (cnt_q == RdivLast) begin
          cnt_d   = 6'd0;
          state_d = ST_RFIN;
        end
      end
      ST_RFIN: begin cnt_d = 6'd0; state_d = ST_MUL; end
      ST_MUL: begin
        if (cnt_q == MulLast) begin
          cnt_d   = 6'd0;
          state_d = ST_DDIV;
        end
      end
      ST_DDIV: begin
        if (cnt_q == DdivLast) begin
          cnt_d   = 6'd0;
          state_d = ST_DFIN;
        end
      end
      ST_DFIN:  begin cnt_d = 6'd0; state_d = ST_BLEND; end
      ST_BLEND: begin cnt_d = 6'd0; state_d = ST_HMOD; end
      ST_HMOD: begin
        if (cnt_q == HmodLast) begin
          cnt_d   = 6'd0;
          state_d = ST_HFIN;
        end
      end
      ST_HFIN: begin
        cnt_d = 6'd0;
        if (fin_go) state_d = ST_IDLE;
      end
      default: begin cnt_d = 6'd0; state_d = ST_IDLE; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // config, filter state, output valid and cordic control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0]    <= 16'd0;
      off_q[1]    <= 16'd0;
      off_q[2]    <= 16'd0;
      sens_q      <= SensReset;
      tilt_x_q    <= 32'd0;
      tilt_y_q    <= 32'd0;
      heading_q   <= 25'd0;
      out_valid_q <= 1'b0;
      cord_run_q  <= 1'b0;
      cord_cnt_q  <= 5'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_OFF_X: off_q[0] <= cfg_wdata_i;
          CFG_OFF_Y: off_q[1] <= cfg_wdata_i;
          CFG_OFF_Z: off_q[2] <= cfg_wdata_i;
          CFG_SENS:  sens_q   <= cfg_wdata_i;
          default:   ;
        endcase
      end
      if (state_q == ST_HFIN && fin_go) begin
        out_valid_q <= 1'b1;
        tilt_x_q    <= nx;
        tilt_y_q    <= ny;
        heading_q   <= hsg[24:0];
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_RFIN) begin
        cord_run_q <= 1'b1;
        cord_cnt_q <= 5'd0;
      end else if (cord_run_q) begin
        if (cord_cnt_q == CordLast) cord_run_q <= 1'b0;
        else cord_cnt_q <= cord_cnt_q + 5'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          acc_q[0] <= accel_x_i;
          acc_q[1] <= accel_y_i;
          acc_q[2] <= accel_z_i;
          gyr_q[0] <= gyro_raw_x_i;
          gyr_q[1] <= gyro_raw_y_i;
          gyr_q[2] <= gyro_raw_z_i;
          ms_q     <= elapsed_ms_i;
        end
      end
      ST_SQ: begin
        for (int k = 0; k < 3; k++) begin
          sq_q[k]   <= 31'($signed(acc_q[k]) * $signed(acc_q[k]));
          rnum_q[k] <= {gmag[k], 24'd0};
          rrem_q[k] <= 16'd0;
          rneg_q[k] <= gdiff[k][16];
        end
      end
      ST_INIT: begin
        sn_q[0] <= {32'(sq_q[1]) + 32'(sq_q[2]), 16'd0};
        sn_q[1] <= {32'(sq_q[0]) + 32'(sq_q[2]), 16'd0};
        for (int k = 0; k < 2; k++) begin
          sres_q[k] <= 48'd0;
          sbit_q[k] <= 48'd1 << 46;
        end
      end
      ST_RDIV: begin
        for (int k = 0; k < 3; k++) begin
          rrem_q[k] <= rge[k] ? 16'(rt[k] - {1'b0, sens_eff}) : rt[k][15:0];
          rnum_q[k] <= {rnum_q[k][38:0], rge[k]};
        end
        for (int k = 0; k < 2; k++) begin
          if (sbit_q[k] != 48'd0) begin
            if (sge[k]) begin
              sn_q[k]   <= sn_q[k] - ssum[k];
              sres_q[k] <= (sres_q[k] >> 1) + sbit_q[k];
            end else begin
              sres_q[k] <= sres_q[k] >> 1;
            end
            sbit_q[k] <= sbit_q[k] >> 2;
          end
        end
      end
      ST_RFIN: begin
        for (int k = 0; k < 3; k++) begin
          rate_q[k] <= rate_n[k];
          rmag_q[k] <= rmag_n[k];
          md_q[k]   <= 48'd0;
          drem_q[k] <= 10'd0;
        end
        msr_q <= ms_q;
        for (int k = 0; k < 2; k++) begin
          cx_q[k]    <= $signed({4'd0, sres_q[k][23:0]});
          cy_q[k]    <= $signed({{4{acc_q[k][15]}}, acc_q[k], 8'd0});
          cz_q[k]    <= 25'sd0;
          czero_q[k] <= (sres_q[k][23:0] == 24'd0) && (acc_q[k] == 16'd0);
        end
      end
      ST_MUL: begin
        for (int k = 0; k < 3; k++)
          md_q[k] <= {md_q[k][46:0], 1'b0} + (msr_q[15] ? {16'd0, rmag_q[k]} : 48'd0);
        msr_q <= {msr_q[14:0], 1'b0};
      end
      ST_DDIV: begin
        for (int k = 0; k < 3; k++) begin
          drem_q[k] <= dge[k] ? 10'(dt[k] - {1'b0, MsPerSec}) : dt[k][9:0];
          md_q[k]   <= {md_q[k][46:0], dge[k]};
        end
      end
      ST_DFIN: begin
        px_q   <= pxs;
        py_q   <= pys;
        hneg_q <= hw[40];
        hm_q   <= hw[40] ? 41'(41'd0 - 41'(hw)) : 41'(hw);
        hrem_q <= 25'd0;
      end
      ST_BLEND: begin
        blx_q <= 50'($signed(px_q) * $signed({1'b0, BlendOld}))
               + 50'(cz_q[0] * $signed({1'b0, BlendAcc})) + 50'sd32768;
        bly_q <= 50'($signed(py_q) * $signed({1'b0, BlendOld}))
               + 50'(cz_q[1] * $signed({1'b0, BlendAcc})) + 50'sd32768;
      end
      ST_HMOD: begin
        hrem_q <= hge ? 25'(ht - {1'b0, Q16Deg360}) : ht[24:0];
        hm_q   <= {hm_q[39:0], 1'b0};
      end
      ST_HFIN: begin
        if (fin_go) begin
          o_ax_q <= nx;
          o_ay_q <= ny;
          o_az_q <= hsg[24:0];
          for (int k = 0; k < 3; k++) o_r_q[k] <= rate_q[k];
        end
      end
      default: ;
    endcase
    // cordic vectoring step, runs beside the multiply and divide
    if (cord_run_q) begin
      for (int k = 0; k < 2; k++) begin
        if (!czero_q[k]) begin
          if (cy_q[k] < 0) begin
            cx_q[k] <= cx_q[k] - cys[k];
            cy_q[k] <= cy_q[k] + cxs[k];
            cz_q[k] <= cz_q[k] - catan;
          end else begin
            cx_q[k] <= cx_q[k] + cys[k];
            cy_q[k] <= cy_q[k] - cxs[k];
            cz_q[k] <= cz_q[k] + catan;
          end
        end
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign angle_x_o   = o_ax_q;
  assign angle_y_o   = o_ay_q;
  assign angle_z_o   = o_az_q;
  assign rate_x_o    = o_r_q[0];
  assign rate_y_o    = o_r_q[1];
  assign rate_z_o    = o_r_q[2];

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(angle_z_o) > -$signed({1'b0, Q16Deg180}))
                 && ($signed(angle_z_o) <= $signed({1'b0, Q16Deg180})))
    else $error("heading out of range");
  a_cordic_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DFIN) |-> !cord_run_q)
    else $error("cordic still busy at blend");
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SQ))
    else $error("accepted item did not start");
  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RFIN) |-> (sbit_q[0] == 48'd0) && (sbit_q[1] == 48'd0))
    else $error("square root unfinished");
`endif

endmodule
